### rtl/bale_pkg.sv
// package with widths, defaults, operation codes and state encoding of the list engine
`default_nettype none

package bale_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned RES_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_REM_FRONT = 3'd3,
    MODE_REM_BACK  = 3'd4,
    MODE_REM_AT    = 3'd5,
    MODE_SEARCH    = 3'd6,
    MODE_CNT_EVEN  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/bounded_array_list_engine_core.sv
// top level of the list engine: entry memory, walk sequencer and result register
// an accepted word walks k entries (k = 0..DEPTH) in ST_WALK, then passes ST_FIN and ST_DONE
// one word in flight: a new word is taken only after the result is loaded; the one read port of the entry memory
//   visits one entry per cycle while shifting, searching or counting
// reset: count cleared, capacity set to 256, no result pending; memory is not cleared
// input stall is high from accept until the result is loaded into the output register
`default_nettype none

module bounded_array_list_engine_core #(
  parameter int unsigned DEPTH = bale_pkg::DEPTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [bale_pkg::MODE_W-1:0]      mode_i,
  input  wire  signed [bale_pkg::DATA_W-1:0] value_i,
  input  wire  [bale_pkg::POS_W-1:0]       position_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             ok_o,
  output logic [bale_pkg::RES_W-1:0]       found_index_o,
  output logic [bale_pkg::RES_W-1:0]       even_count_o,
  output logic [bale_pkg::RES_W-1:0]       size_o,
  output logic                             full_res_o,
  output logic                             empty_res_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [bale_pkg::CAP_W-1:0]       cfg_data_i
);
  import bale_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW + 1 > 10) ? CW + 1 : 10;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  mode_e             op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [XW-1:0]     p_q, p_d;
  logic              ok_q, ok_d;
  logic [XW-1:0]     cur_q, cur_d;
  logic [XW-1:0]     left_q, left_d;
  logic              pend_q, pend_d;
  logic [XW-1:0]     pend_idx_q, pend_idx_d;
  logic [CW-1:0]     found_q, found_d;
  logic [CW-1:0]     evens_q, evens_d;
  logic              out_valid_q, out_valid_d;
  logic              res_ok_q, res_ok_d;
  logic [RES_W-1:0]  res_found_q, res_found_d;
  logic [RES_W-1:0]  res_even_q, res_even_d;
  logic [RES_W-1:0]  res_size_q, res_size_d;
  logic              res_full_q, res_full_d;
  logic              res_empty_q, res_empty_d;

  logic [XW-1:0] n_x, cap_x, depth_x, effcap_x, pos_x, p_new, wa_x;
  logic          full_now, in_mode_ins, in_mode_rem, op_ins, op_rem, ins_ok, rem_ok;
  logic          out_free;
  mode_e         in_mode;

  assign in_mode     = mode_e'(mode_i);
  assign n_x         = XW'(count_q);
  assign cap_x       = XW'(cap_q);
  assign depth_x     = XW'(DEPTH);
  assign effcap_x    = (cap_x > depth_x) ? depth_x : cap_x;
  assign full_now    = n_x >= effcap_x;
  assign pos_x       = XW'(position_i);
  assign in_mode_ins = in_mode inside {MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT};
  assign in_mode_rem = in_mode inside {MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_AT};
  assign op_ins      = op_q inside {MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT};
  assign op_rem      = op_q inside {MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_AT};
  assign ins_ok      = !full_now && (p_new != '0) && (p_new <= n_x + XW'(1));
  assign rem_ok      = (n_x != '0) && (p_new != '0) && (p_new <= n_x);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign in_stall_o    = state_q != ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign ok_o          = res_ok_q;
  assign found_index_o = res_found_q;
  assign even_count_o  = res_even_q;
  assign size_o        = res_size_q;
  assign full_res_o    = res_full_q;
  assign empty_res_o   = res_empty_q;

  always_comb begin
    case (in_mode)
      MODE_INS_FRONT: p_new = XW'(1);
      MODE_INS_BACK:  p_new = n_x + XW'(1);
      MODE_INS_AT:    p_new = pos_x;
      MODE_REM_FRONT: p_new = XW'(1);
      MODE_REM_BACK:  p_new = n_x;
      MODE_REM_AT:    p_new = pos_x;
      default:        p_new = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_WALK;
      ST_WALK: if (left_q == '0 && !pend_q) state_d = ST_FIN;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    cap_d       = cap_q;
    op_d        = op_q;
    val_d       = val_q;
    p_d         = p_q;
    ok_d        = ok_q;
    cur_d       = cur_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    evens_d     = evens_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_even_d  = res_even_q;
    res_size_d  = res_size_q;
    res_full_d  = res_full_q;
    res_empty_d = res_empty_q;
    we          = 1'b0;
    re          = 1'b0;
    wa_x        = '0;
    wdata       = rdata_q;
    raddr       = cur_q[AW-1:0];

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    if (state_q == ST_IDLE && in_valid_i) begin
      op_d    = in_mode;
      val_d   = value_i;
      p_d     = p_new;
      found_d = '0;
      evens_d = '0;
      ok_d    = 1'b0;
      left_d  = '0;
      cur_d   = '0;
      if (in_mode_ins) begin
        ok_d = ins_ok;
        if (ins_ok) begin
          cur_d  = n_x - XW'(1);
          left_d = n_x + XW'(1) - p_new;
        end
      end else if (in_mode_rem) begin
        ok_d = rem_ok;
        if (rem_ok) begin
          cur_d  = p_new;
          left_d = n_x - p_new;
        end
      end else begin
        left_d = n_x;
      end
    end

    if (state_q == ST_WALK) begin
      if (left_q != '0) begin
        re         = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = cur_q;
        cur_d      = op_ins ? cur_q - XW'(1) : cur_q + XW'(1);
        left_d     = left_q - XW'(1);
      end
      if (pend_q) begin
        if (op_ins) begin
          we   = 1'b1;
          wa_x = pend_idx_q + XW'(1);
        end else if (op_rem) begin
          we   = 1'b1;
          wa_x = pend_idx_q - XW'(1);
        end else if (op_q == MODE_SEARCH) begin
          if (rdata_q == val_q && found_q == '0) begin
            found_d = CW'(pend_idx_q + XW'(1));
          end
        end else if (!rdata_q[0]) begin
          evens_d = evens_q + CW'(1);
        end
      end
    end

    if (state_q == ST_FIN && ok_q) begin
      if (op_ins) begin
        we      = 1'b1;
        wa_x    = p_q - XW'(1);
        wdata   = val_q;
        count_d = count_q + CW'(1);
      end else if (op_rem) begin
        count_d = count_q - CW'(1);
      end
    end

    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      res_ok_d    = ok_q;
      res_found_d = RES_W'(found_q);
      res_even_d  = RES_W'(evens_q);
      res_size_d  = RES_W'(count_q);
      res_full_d  = full_now;
      res_empty_d = count_q == '0;
    end

    waddr = wa_x[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    p_q         <= p_d;
    ok_q        <= ok_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    pend_idx_q  <= pend_idx_d;
    found_q     <= found_d;
    evens_q     <= evens_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_even_q  <= res_even_d;
    res_size_q  <= res_size_d;
    res_full_q  <= res_full_d;
    res_empty_q <= res_empty_d;
  end

endmodule

`default_nettype wire

### rtl/bale_chk.sv
// port-level assertion checker for the list engine and its bind
`default_nettype none

module bale_chk (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_stall_o,
  input wire                         out_valid_o,
  input wire                         out_stall_i,
  input wire [bale_pkg::RES_W-1:0]   found_index_o,
  input wire [bale_pkg::RES_W-1:0]   even_count_o,
  input wire [bale_pkg::RES_W-1:0]   size_o,
  input wire                         empty_res_o
);

  // a held result word keeps its size
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(size_o))
    else $error("held result word changed");

  // one item in flight: an accepted word stalls the input next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_res_o == (size_o == '0)))
    else $error("empty flag disagrees with size");

  // an empty list has nothing to find or count
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> found_index_o == '0 && even_count_o == '0)
    else $error("nonzero search or count result on empty list");

endmodule

bind bounded_array_list_engine_core bale_chk u_bale_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .found_index_o (found_index_o),
  .even_count_o  (even_count_o),
  .size_o        (size_o),
  .empty_res_o   (empty_res_o)
);

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the bounded array list engine core
`timescale 1ns / 1ps

module testbench;
  import bale_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic       ok;
    logic [8:0] found_index;
    logic [8:0] even_count;
    logic [8:0] size;
    logic       full;
    logic       empty;
  } op_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic ok_o;
  logic [RES_W-1:0] found_index_o;
  logic [RES_W-1:0] even_count_o;
  logic [RES_W-1:0] size_o;
  logic full_res_o;
  logic empty_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;

  // predicted list state
  logic [31:0] list_mem [LIST_DEPTH];
  int unsigned list_len = 0;
  logic [8:0] list_cap = CAP_RESET;

  op_result_t op_result_q[$];
  int unsigned err_cnt = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int unsigned stall_left = 0;

  bounded_array_list_engine_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .found_index_o(found_index_o),
    .even_count_o (even_count_o),
    .size_o       (size_o),
    .full_res_o   (full_res_o),
    .empty_res_o  (empty_res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit list_full();
    int unsigned eff_cap;
    eff_cap = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
    return list_len >= eff_cap;
  endfunction

  function automatic bit list_insert(input int unsigned pos, input logic [31:0] v);
    if (list_full() || pos < 1 || pos > list_len + 1) return 1'b0;
    for (int i = int'(list_len); i >= int'(pos); i--) list_mem[i] = list_mem[i-1];
    list_mem[pos-1] = v;
    list_len++;
    return 1'b1;
  endfunction

  function automatic bit list_remove(input int unsigned pos);
    if (list_len == 0 || pos < 1 || pos > list_len) return 1'b0;
    for (int unsigned i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return 1'b1;
  endfunction

  function automatic op_result_t apply_list_op(input mode_e m, input logic [31:0] v,
                                               input logic [8:0] p);
    op_result_t r;
    r = '0;
    case (m)
      MODE_INS_FRONT: r.ok = list_insert(1, v);
      MODE_INS_BACK:  r.ok = list_insert(list_len + 1, v);
      MODE_INS_AT:    r.ok = list_insert(p, v);
      MODE_REM_FRONT: r.ok = list_remove(1);
      MODE_REM_BACK:  r.ok = list_remove(list_len);
      MODE_REM_AT:    r.ok = list_remove(p);
      MODE_SEARCH: begin
        for (int unsigned i = 0; i < list_len; i++)
          if (r.found_index == 0 && list_mem[i] == v) r.found_index = 9'(i + 1);
      end
      default: begin
        for (int unsigned i = 0; i < list_len; i++)
          if (!list_mem[i][0]) r.even_count++;
      end
    endcase
    r.size  = 9'(list_len);
    r.full  = list_full();
    r.empty = (list_len == 0);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 16) - 8;
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // one word per call, held until accepted; called at a falling edge
  task automatic send_op(input mode_e m, input logic [31:0] v, input logic [8:0] p);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i     = m;
    value_i    = v;
    position_i = p;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    op_result_q.push_back(apply_list_op(m, v, p));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (op_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] c);
    drain_results();
    cfg_data_i  = c;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    list_cap = c;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random_op();
    int unsigned r;
    mode_e m;
    logic [31:0] v;
    logic [8:0] p;
    r = $urandom_range(0, 99);
    if (r < 14)      m = MODE_INS_FRONT;
    else if (r < 28) m = MODE_INS_BACK;
    else if (r < 40) m = MODE_INS_AT;
    else if (r < 50) m = MODE_REM_FRONT;
    else if (r < 60) m = MODE_REM_BACK;
    else if (r < 75) m = MODE_REM_AT;
    else if (r < 90) m = MODE_SEARCH;
    else             m = MODE_CNT_EVEN;
    if (m == MODE_SEARCH && list_len != 0 && $urandom_range(0, 9) < 6)
      v = list_mem[$urandom_range(0, list_len - 1)];
    else
      v = pick_value();
    if ($urandom_range(0, 4) == 0) p = 9'($urandom_range(0, 511));
    else p = 9'($urandom_range(0, list_len + 2));
    send_op(m, v, p);
  endtask

  task automatic test_directed_ops();
    send_op(MODE_REM_FRONT, 32'd0, 9'd0);
    send_op(MODE_REM_BACK, 32'd0, 9'd0);
    send_op(MODE_REM_AT, 32'd0, 9'd1);
    send_op(MODE_SEARCH, 32'd0, 9'd0);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
    send_op(MODE_INS_AT, 32'd5, 9'd0);
    send_op(MODE_INS_AT, 32'd5, 9'd2);
    send_op(MODE_INS_AT, 32'h8000_0000, 9'd1);
    send_op(MODE_INS_FRONT, 32'h7fff_ffff, 9'd0);
    send_op(MODE_INS_BACK, 32'hffff_ffff, 9'd0);
    send_op(MODE_INS_BACK, 32'hffff_fffe, 9'd0);
    send_op(MODE_INS_AT, 32'd9, 9'd511);
    send_op(MODE_INS_AT, 32'd9, 9'd6);
    send_op(MODE_INS_AT, 32'h7fff_ffff, 9'd5);
    send_op(MODE_INS_AT, 32'd0, 9'd3);
    send_op(MODE_SEARCH, 32'h7fff_ffff, 9'd0);
    send_op(MODE_SEARCH, 32'hffff_ffff, 9'd0);
    send_op(MODE_SEARCH, 32'h1234_5678, 9'd0);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
    send_op(MODE_REM_AT, 32'd0, 9'd0);
    send_op(MODE_REM_AT, 32'd0, 9'd7);
    send_op(MODE_REM_AT, 32'd0, 9'd6);
    send_op(MODE_REM_AT, 32'd0, 9'd3);
    send_op(MODE_REM_FRONT, 32'd0, 9'd0);
    send_op(MODE_REM_BACK, 32'd0, 9'd0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(9'd0);
    send_op(MODE_INS_FRONT, 32'd11, 9'd0);
    send_op(MODE_INS_BACK, 32'd12, 9'd0);
    send_op(MODE_INS_AT, 32'd13, 9'd1);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
    while (list_len != 0) send_op(MODE_REM_FRONT, 32'd0, 9'd0);
    send_op(MODE_INS_BACK, 32'd14, 9'd0);
    write_capacity(9'd1);
    send_op(MODE_INS_BACK, 32'd7, 9'd0);
    send_op(MODE_INS_FRONT, 32'd8, 9'd0);
    send_op(MODE_INS_AT, 32'd8, 9'd1);
    send_op(MODE_SEARCH, 32'd7, 9'd0);
    send_op(MODE_REM_AT, 32'd0, 9'd1);
    write_capacity(9'd3);
    send_op(MODE_INS_BACK, 32'd2, 9'd0);
    send_op(MODE_INS_BACK, 32'd4, 9'd0);
    send_op(MODE_INS_BACK, 32'd6, 9'd0);
    // capacity below the current count
    write_capacity(9'd2);
    send_op(MODE_INS_FRONT, 32'd1, 9'd0);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
    send_op(MODE_REM_FRONT, 32'd0, 9'd0);
    send_op(MODE_REM_BACK, 32'd0, 9'd0);
    send_op(MODE_INS_BACK, 32'd3, 9'd0);
    write_capacity(9'd511);
    send_op(MODE_INS_FRONT, 32'hdead_beef, 9'd0);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
  endtask

  task automatic test_full_depth();
    int unsigned i;
    write_capacity(9'd256);
    while (list_len != 0) send_op(MODE_REM_BACK, 32'd0, 9'd0);
    for (i = 0; i < LIST_DEPTH; i++) begin
      if (i % 16 == 5) send_op(MODE_INS_AT, pick_value(), 9'($urandom_range(1, list_len + 1)));
      else send_op(MODE_INS_BACK, pick_value(), 9'd0);
    end
    send_op(MODE_INS_FRONT, 32'd1, 9'd0);
    send_op(MODE_INS_BACK, 32'd2, 9'd0);
    send_op(MODE_INS_AT, 32'd3, 9'd257);
    send_op(MODE_SEARCH, list_mem[LIST_DEPTH-1], 9'd0);
    send_op(MODE_SEARCH, $urandom(), 9'd0);
    send_op(MODE_CNT_EVEN, 32'd0, 9'd0);
    write_capacity(9'd100);
    send_op(MODE_INS_BACK, 32'd5, 9'd0);
    send_op(MODE_REM_AT, 32'd0, 9'd256);
    send_op(MODE_REM_AT, 32'd0, 9'd256);
    write_capacity(9'd511);
    send_op(MODE_INS_FRONT, pick_value(), 9'd0);
    send_op(MODE_INS_BACK, pick_value(), 9'd0);
    while (list_len != 0) begin
      case ($urandom_range(0, 15))
        0:       send_op(MODE_REM_AT, 32'd0, 9'($urandom_range(1, list_len)));
        1:       send_op(MODE_REM_FRONT, 32'd0, 9'd0);
        default: send_op(MODE_REM_BACK, 32'd0, 9'd0);
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int unsigned ph;
    logic [8:0] cap_sel;
    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0:       cap_sel = 9'd1;
        1:       cap_sel = 9'd4;
        2:       cap_sel = 9'd8;
        3:       cap_sel = 9'd16;
        4:       cap_sel = 9'd0;
        5:       cap_sel = 9'd256;
        6:       cap_sel = 9'd511;
        7:       cap_sel = 9'($urandom_range(2, 32));
        8:       cap_sel = 9'($urandom_range(33, 255));
        9:       cap_sel = 9'($urandom_range(1, 12));
        default: cap_sel = 9'($urandom_range(0, 511));
      endcase
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      write_capacity(cap_sel);
      repeat (62) send_random_op();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (err_cnt < 200)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (rx_idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    op_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (op_result_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        err_cnt++;
      end else begin
        want = op_result_q.pop_front();
        check_field("ok", want.ok, ok_o);
        check_field("found_index", want.found_index, found_index_o);
        check_field("even_count", want.even_count, even_count_o);
        check_field("size", want.size, size_o);
        check_field("full_res", want.full, full_res_o);
        check_field("empty_res", want.empty, empty_res_o);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout", $time);
    $display("bounded_array_list_engine_core regression: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_ops();
    test_capacity_limits();
    test_full_depth();
    test_random_traffic();
    drain_results();
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (err_cnt == 0 && op_result_q.size() == 0)
      $display("bounded_array_list_engine_core regression: pass");
    else
      $display("bounded_array_list_engine_core regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/bale_pkg.sv
rtl/bounded_array_list_engine_core.sv
rtl/bale_chk.sv
tb/testbench.sv
